// ----- rtl/core/horizontal_line_mirror_core_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the line mirror core
// Implication checks sampled on clk_i, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef HORIZONTAL_LINE_MIRROR_CORE_ASSERT_SVH
`define HORIZONTAL_LINE_MIRROR_CORE_ASSERT_SVH

// same-cycle implication
`define HLM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HLM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/hlm_pkg.sv -----
// ----------------------------------------------------------------------------
// hlm_pkg
// Shared constants, types and helpers of the line mirror core.
// ----------------------------------------------------------------------------
`default_nettype none

package hlm_pkg;

  localparam int unsigned MAX_LINE_BYTES_DEF = 8192;

  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned LINE_BYTES_W = 14;
  localparam int unsigned CFG_DATA_W   = LINE_BYTES_W;

  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_FORMAT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_BYTES   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIRROR_ON    = 2'd2;

  localparam logic [1:0] FMT_PACKED8  = 2'd0;
  localparam logic [1:0] FMT_PACKED16 = 2'd1;
  localparam logic [1:0] FMT_PACKED24 = 2'd2;
  localparam logic [1:0] FMT_PLANAR   = 2'd3;

  localparam logic OP_DATA  = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QLVL_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic valid;
    logic last;
    logic flip;
  } hlm_tag_t;

  typedef struct packed {
    logic              room;
    logic [QLVL_W-1:0] level;
  } hlm_bstat_t;

  function automatic logic [1:0] pix_size(input logic [1:0] fmt);
    logic [1:0] s;
    case (fmt)
      FMT_PACKED16: s = 2'd2;
      FMT_PACKED24: s = 2'd3;
      default:      s = 2'd1;
    endcase
    return s;
  endfunction

  function automatic logic [7:0] flip_bits(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = v[7-i];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/horizontal_line_mirror_core.sv -----
// ----------------------------------------------------------------------------
// horizontal_line_mirror_core
// Left-to-right line mirror with two alternating line stores.
// ----------------------------------------------------------------------------
// One item per clock is accepted: each data byte is written into the current
// line bank while the matching byte of the previous line is read from the
// other bank, so the single write port and single read port of the line-store
// RAM set the rate of one item per cycle. A result passes the registered RAM
// read, then the four-entry output queue, and the input keeps flowing while
// fewer than four results are queued or being read.
// No result appears for the first line or for flushes with no stored line.
// The line store needs no clearing after reset.
`default_nettype none
`include "horizontal_line_mirror_core_assert.svh"

module horizontal_line_mirror_core #(
  parameter int unsigned MAX_LINE_BYTES = hlm_pkg::MAX_LINE_BYTES_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [hlm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [hlm_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [7:0]                     s_axis_tdata,  // [7:0] pixel_byte
  input  wire logic                           s_axis_tuser,  // [0] operation
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  output logic      [7:0]                     m_axis_tdata,  // [7:0] out_byte
  output logic                                m_axis_tlast
);

  import hlm_pkg::*;

  localparam int unsigned POS_W     = $clog2(MAX_LINE_BYTES);
  localparam int unsigned AW        = POS_W + 1;
  localparam int unsigned RAM_DEPTH = 2 ** AW;
  localparam logic [QLVL_W-1:0] LVL_FULL = QLVL_W'(QDEPTH);

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;
  hlm_tag_t      tag;
  hlm_bstat_t    bstat;

  assign s_axis_tready = bstat.room;

  hlm_front #(
    .MAX_LINE_BYTES(MAX_LINE_BYTES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .s_valid_i   (s_axis_tvalid),
    .s_room_i    (bstat.room),
    .s_op_i      (s_axis_tuser),
    .s_data_i    (s_axis_tdata),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .tag_o       (tag)
  );

  hlm_ram #(
    .WIDTH(8),
    .DEPTH(RAM_DEPTH)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  hlm_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .tag_i     (tag),
    .rdata_i   (ram_rdata),
    .bstat_o   (bstat),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_data_o  (m_axis_tdata),
    .m_last_o  (m_axis_tlast)
  );

  `HLM_ASSERT_IMP(a_queue_bound, 1'b1, bstat.level <= LVL_FULL, "queue overflow")
  `HLM_ASSERT_NXT(a_tag_needs_accept, !(s_axis_tvalid && s_axis_tready), !tag.valid, "stray read")
  `HLM_ASSERT_IMP(a_full_stall, bstat.level == LVL_FULL, !s_axis_tready, "ready when full")

endmodule

`default_nettype wire

// ----- rtl/core/hlm_ram.sv -----
// ----------------------------------------------------------------------------
// hlm_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module hlm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/hlm_front.sv -----
// ----------------------------------------------------------------------------
// hlm_front
// Accept and classify items, hold configuration and line state, drive the
// line-store write and the mirrored (or, with mirroring off, straight) read of the previous line.
// ----------------------------------------------------------------------------
`default_nettype none

module hlm_front #(
  parameter int unsigned MAX_LINE_BYTES = hlm_pkg::MAX_LINE_BYTES_DEF,
  localparam int unsigned POS_W = $clog2(MAX_LINE_BYTES),
  localparam int unsigned AW = POS_W + 1
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [hlm_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [hlm_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  wire logic                            s_valid_i,
  input  wire logic                            s_room_i,
  input  wire logic                            s_op_i,
  input  wire logic [7:0]                      s_data_i,
  output logic                                 ram_we_o,
  output logic      [AW-1:0]                   ram_waddr_o,
  output logic      [7:0]                      ram_wdata_o,
  output logic                                 ram_re_o,
  output logic      [AW-1:0]                   ram_raddr_o,
  output hlm_pkg::hlm_tag_t                    tag_o
);

  import hlm_pkg::*;

  localparam int unsigned LEN_W = $clog2(MAX_LINE_BYTES + 1);
  localparam int unsigned CMP_W = (LEN_W > LINE_BYTES_W) ? LEN_W : LINE_BYTES_W;

  logic [1:0]       fmt_q;
  logic [LEN_W-1:0] len_q;
  logic             mirror_q;
  logic             bank_q;
  logic [POS_W-1:0] pos_q;
  logic [1:0]       phase_q;
  logic             plv_q;
  hlm_tag_t         tag_q;

  logic [CMP_W-1:0] lb_ext;
  logic [LEN_W-1:0] len_d;
  logic [1:0]       size;
  logic [1:0]       phase_inc;
  logic [1:0]       phase_d;
  logic [LEN_W-1:0] start;
  logic [LEN_W-1:0] rem;
  logic [LEN_W-1:0] src_w;
  logic             last;
  logic             fire;
  logic             is_flush;
  logic             act;
  logic             emit;

  always_comb begin
    lb_ext = CMP_W'(cfg_data_i[LINE_BYTES_W-1:0]);
    if (lb_ext == '0) begin
      len_d = LEN_W'(1);
    end else if (lb_ext > CMP_W'(MAX_LINE_BYTES)) begin
      len_d = LEN_W'(MAX_LINE_BYTES);
    end else begin
      len_d = LEN_W'(lb_ext);
    end
  end

  always_comb begin
    size  = pix_size(fmt_q);
    start = LEN_W'(pos_q) - LEN_W'(phase_q);
    rem   = len_q - start;
    if (!mirror_q) begin
      src_w = LEN_W'(pos_q);
    end else if (rem >= LEN_W'(size)) begin
      src_w = rem - LEN_W'(size) + LEN_W'(phase_q);
    end else begin
      src_w = len_q - LEN_W'(1) - LEN_W'(pos_q);
    end
    phase_inc = phase_q + 2'd1;
    phase_d   = (phase_inc >= size) ? 2'd0 : phase_inc;
  end

  assign last     = (LEN_W'(pos_q) == (len_q - LEN_W'(1)));
  assign fire     = s_valid_i & s_room_i;
  assign is_flush = (s_op_i == OP_FLUSH);
  assign act      = fire & ~(is_flush & ~plv_q);
  assign emit     = fire & plv_q;

  assign ram_we_o    = act;
  assign ram_waddr_o = {bank_q, pos_q};
  assign ram_wdata_o = is_flush ? 8'h00 : s_data_i;
  assign ram_re_o    = emit;
  assign ram_raddr_o = {~bank_q, src_w[POS_W-1:0]};
  assign tag_o       = tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q    <= FMT_PACKED8;
      len_q    <= LEN_W'(1);
      mirror_q <= 1'b1;
      bank_q   <= 1'b0;
      pos_q    <= '0;
      phase_q  <= '0;
      plv_q    <= 1'b0;
      tag_q    <= '0;
    end else begin
      tag_q.valid <= emit;
      tag_q.last  <= last;
      tag_q.flip  <= mirror_q & (fmt_q == FMT_PLANAR);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_PIXEL_FORMAT: begin
            fmt_q   <= cfg_data_i[1:0];
            pos_q   <= '0;
            phase_q <= '0;
            plv_q   <= 1'b0;
          end
          CFG_LINE_BYTES: begin
            len_q   <= len_d;
            pos_q   <= '0;
            phase_q <= '0;
            plv_q   <= 1'b0;
          end
          CFG_MIRROR_ON: begin
            mirror_q <= cfg_data_i[0];
          end
          default: begin
          end
        endcase
      end else if (act) begin
        if (last) begin
          pos_q   <= '0;
          phase_q <= '0;
          bank_q  <= ~bank_q;
          plv_q   <= ~is_flush;
        end else begin
          pos_q   <= pos_q + POS_W'(1);
          phase_q <= phase_d;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/hlm_back.sv -----
// ----------------------------------------------------------------------------
// hlm_back
// Finish read bytes (bit flip for mirrored planar rows) and queue them for the output.
// ----------------------------------------------------------------------------
`default_nettype none

module hlm_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire hlm_pkg::hlm_tag_t tag_i,
  input  wire logic [7:0]    rdata_i,
  output hlm_pkg::hlm_bstat_t bstat_o,
  output logic               m_valid_o,
  input  wire logic          m_ready_i,
  output logic [7:0]         m_data_o,
  output logic               m_last_o
);

  import hlm_pkg::*;

  logic [8:0]        fifo_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q;
  logic [QPTR_W-1:0] rd_ptr_q;
  logic [QLVL_W-1:0] level_q;
  logic [7:0]        byte_fin;
  logic              push;
  logic              pop;

  assign byte_fin  = tag_i.flip ? flip_bits(rdata_i) : rdata_i;
  assign push      = tag_i.valid;
  assign m_valid_o = (level_q != '0);
  assign pop       = m_valid_o & m_ready_i;
  assign m_data_o  = fifo_q[rd_ptr_q][7:0];
  assign m_last_o  = fifo_q[rd_ptr_q][8];

  assign bstat_o.level = level_q;
  assign bstat_o.room  = ((QLVL_W + 1)'(level_q) + (QLVL_W + 1)'(tag_i.valid))
                         < (QLVL_W + 1)'(QDEPTH);

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= {tag_i.last, byte_fin};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   level_q <= level_q + QLVL_W'(1);
        2'b01:   level_q <= level_q - QLVL_W'(1);
        default: level_q <= level_q;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- tb/sv/horizontal_line_mirror_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// horizontal_line_mirror_core_tb
// Streams pixel and flush items through the line mirror in all four formats.
// Line lengths cover the minimum, zero and small sizes. Each accepted item
// updates a local two-bank line model, which predicts the mirrored or
// delayed output byte and its line-end flag. Results are checked in order
// against that model. Both streams idle at random.
// ----------------------------------------------------------------------------
module horizontal_line_mirror_core_tb;
  import hlm_pkg::*;

  localparam int unsigned LINE_MAX = MAX_LINE_BYTES_DEF;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic       op;
    logic [7:0] pix;
  } pixel_item_t;

  typedef struct packed {
    logic [7:0] pix;
    logic       last;
  } mirror_byte_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata  = '0;   // [7:0] pixel_byte
  logic                  s_axis_tuser  = OP_DATA; // [0] operation
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [7:0]            m_axis_tdata;         // [7:0] out_byte
  logic                  m_axis_tlast;

  pixel_item_t  pixel_q[$];
  mirror_byte_t mirrored_q[$];
  int unsigned  errors  = 0;
  bit           no_gaps = 1'b0;

  logic [7:0]   line_copy [0:2*LINE_MAX-1];
  logic         wr_bank   = 1'b0;
  int unsigned  byte_pos  = 0;
  int unsigned  pix_phase = 0;
  bit           have_line = 1'b0;
  logic [1:0]   fmt_q     = FMT_PACKED8;
  logic [13:0]  len_q     = 14'd1;
  logic         mirror_q  = 1'b1;

  horizontal_line_mirror_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  function automatic int unsigned line_len();
    if (len_q == 14'd0) return 1;
    if (len_q > LINE_MAX) return LINE_MAX;
    return len_q;
  endfunction

  function automatic int unsigned pixel_bytes();
    case (fmt_q)
      FMT_PACKED16: return 2;
      FMT_PACKED24: return 3;
      default:      return 1;
    endcase
  endfunction

  task automatic predict_mirror_byte(input logic op, input logic [7:0] pix);
    int unsigned len, psz, pos, ph, start, src, rd_base, wr_base;
    logic [7:0]  v;
    len = line_len();
    psz = pixel_bytes();
    pos = byte_pos;
    ph  = pix_phase;
    rd_base = wr_bank ? 0 : LINE_MAX;
    wr_base = wr_bank ? LINE_MAX : 0;
    if (pos >= len) begin
      pos = 0;
      ph  = 0;
    end
    if (ph >= psz) ph = 0;
    if (op == OP_FLUSH && !have_line) return;
    if (have_line) begin
      if (!mirror_q) begin
        src = pos;
      end else begin
        start = pos - ph;
        if (len - start >= psz) src = len - start - psz + ph;
        else src = len - 1 - pos;
      end
      v = line_copy[rd_base + src];
      if (mirror_q && fmt_q == FMT_PLANAR) v = {<<{v}};
      mirrored_q.push_back('{pix: v, last: (pos == len - 1)});
    end
    line_copy[wr_base + pos] = (op == OP_FLUSH) ? 8'h00 : pix;
    pos++;
    ph++;
    if (ph >= psz) ph = 0;
    if (pos >= len) begin
      pos       = 0;
      ph        = 0;
      wr_bank   = ~wr_bank;
      have_line = (op == OP_DATA);
    end
    byte_pos  = pos;
    pix_phase = ph;
  endtask

  task automatic flag_error(input string what);
    if (errors < 10) $display("%0t: %s", $time, what);
    errors++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_PIXEL_FORMAT: begin
        fmt_q     = val[1:0];
        byte_pos  = 0;
        pix_phase = 0;
        have_line = 1'b0;
      end
      CFG_LINE_BYTES: begin
        len_q     = val;
        byte_pos  = 0;
        pix_phase = 0;
        have_line = 1'b0;
      end
      CFG_MIRROR_ON: begin
        mirror_q = val[0];
      end
      default: begin
      end
    endcase
  endtask

  task automatic push_item(input logic op, input logic [7:0] pix);
    pixel_q.push_back('{op: op, pix: pix});
  endtask

  task automatic queue_lines(input int unsigned lines, input int unsigned extra,
                             input int unsigned flush_pct, input int unsigned drain);
    int unsigned n;
    n = line_len();
    repeat (lines * n + extra)
      push_item(($urandom_range(99) < flush_pct) ? OP_FLUSH : OP_DATA, 8'($urandom));
    repeat (drain * n)
      push_item(OP_FLUSH, 8'($urandom));
  endtask

  // hold until the item stream and the result stream are both empty
  task automatic wait_quiet();
    do @(negedge clk_i);
    while (pixel_q.size() != 0 || s_axis_tvalid || mirrored_q.size() != 0);
    repeat (8) @(negedge clk_i);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : feed_pixels
    pixel_item_t nxt;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= OP_DATA;
    end else begin
      if (s_axis_tvalid && s_axis_tready) predict_mirror_byte(s_axis_tuser, s_axis_tdata);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pixel_q.size() != 0 && (no_gaps || $urandom_range(99) >= 6)) begin
          nxt = pixel_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= nxt.pix;
          s_axis_tuser  <= nxt.op;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : check_mirrored
    mirror_byte_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (mirrored_q.size() == 0) begin
          flag_error($sformatf("unexpected byte %02h last %0b", m_axis_tdata, m_axis_tlast));
        end else begin
          want = mirrored_q.pop_front();
          if (m_axis_tdata !== want.pix)
            flag_error($sformatf("out_byte: expected %02h, got %02h", want.pix, m_axis_tdata));
          if (m_axis_tlast !== want.last)
            flag_error($sformatf("line_end: expected %0b, got %0b", want.last, m_axis_tlast));
        end
      end
      m_axis_tready <= no_gaps || ($urandom_range(99) >= 6);
    end
  end

  initial begin
    logic [7:0]  corner [7];
    int unsigned sent, phase_no, n, len;
    corner   = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h55, 8'hAA, 8'h7F};
    sent     = 0;
    phase_no = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // 24-bit pixels with a partial trailing pixel, then drain and an idle flush
    write_reg(CFG_PIXEL_FORMAT, {12'h000, FMT_PACKED24});
    write_reg(CFG_LINE_BYTES, 14'd7);
    write_reg(CFG_MIRROR_ON, 14'd1);
    foreach (corner[i]) push_item(OP_DATA, corner[i]);
    foreach (corner[i]) push_item(OP_DATA, ~corner[i]);
    repeat (7) push_item(OP_FLUSH, 8'hFF);
    push_item(OP_FLUSH, 8'h00);
    wait_quiet();

    // planar, zero length acts as one, unused index
    write_reg(CFG_UNUSED, 14'h3FFF);
    write_reg(CFG_PIXEL_FORMAT, 14'h3FFF);
    write_reg(CFG_LINE_BYTES, 14'd0);
    push_item(OP_DATA, 8'h01);
    push_item(OP_DATA, 8'h80);
    push_item(OP_FLUSH, 8'h5A);
    push_item(OP_FLUSH, 8'hA5);
    wait_quiet();

    while (sent < 2000) begin
      if ($urandom_range(99) < 60) write_reg(CFG_PIXEL_FORMAT, 14'($urandom));
      if ($urandom_range(99) < 60) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(1) : $urandom_range(2, 24);
        write_reg(CFG_LINE_BYTES, 14'(len));
      end
      if ($urandom_range(99) < 50) write_reg(CFG_MIRROR_ON, 14'($urandom));
      no_gaps = (phase_no >= 10 && phase_no < 16);
      n = line_len();
      queue_lines($urandom_range(1, 5), ($urandom_range(1) != 0) ? $urandom_range(n - 1) : 0,
                  4, $urandom_range(2));
      sent += pixel_q.size();
      phase_no++;
      wait_quiet();
    end
    no_gaps = 1'b0;

    if (errors == 0) begin
      $display("horizontal_line_mirror_core_tb: done, clean");
    end else begin
      $display("horizontal_line_mirror_core_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("horizontal_line_mirror_core_tb: done, errors");
    $finish;
  end

endmodule
